// File: sv/psd_pkg.sv
package psd_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;

  typedef enum logic [1:0] {
    SEL_START,
    SEL_END,
    SEL_PERP
  } sel_e;

  typedef struct packed {
    logic valid;
    sel_e sel;
  } ctl_t;

endpackage

// File: sv/psd_front.sv
module psd_front
  import psd_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH-1:0] qx_i,
  input  logic signed [COORD_WIDTH-1:0] qy_i,
  input  logic signed [COORD_WIDTH-1:0] sx_i,
  input  logic signed [COORD_WIDTH-1:0] sy_i,
  input  logic signed [COORD_WIDTH-1:0] ex_i,
  input  logic signed [COORD_WIDTH-1:0] ey_i,
  output logic                          valid_o,
  output logic [2*COORD_WIDTH+1:0]      den_o,
  output logic signed [2*COORD_WIDTH+2:0] dot_o,
  output logic signed [2*COORD_WIDTH+2:0] cross_o,
  output logic [2*COORD_WIDTH+1:0]      lenw_o,
  output logic [2*COORD_WIDTH+1:0]      lenv_o
);

  localparam int unsigned D = COORD_WIDTH + 1;
  localparam int unsigned P = 2 * COORD_WIDTH + 2;
  localparam int unsigned S = 2 * COORD_WIDTH + 3;

  logic signed [D-1:0] dx_q, dy_q, wx_q, wy_q, vx_q, vy_q;
  logic                v1_q, v2_q, v3_q;
  logic signed [P-1:0] dxdx_q, dydy_q, wxdx_q, wydy_q, wxdy_q, wydx_q;
  logic signed [P-1:0] wxwx_q, wywy_q, vxvx_q, vyvy_q;

  // stage 1: differences
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q <= {ex_i[COORD_WIDTH-1], ex_i} - {sx_i[COORD_WIDTH-1], sx_i};
    dy_q <= {ey_i[COORD_WIDTH-1], ey_i} - {sy_i[COORD_WIDTH-1], sy_i};
    wx_q <= {qx_i[COORD_WIDTH-1], qx_i} - {sx_i[COORD_WIDTH-1], sx_i};
    wy_q <= {qy_i[COORD_WIDTH-1], qy_i} - {sy_i[COORD_WIDTH-1], sy_i};
    vx_q <= {qx_i[COORD_WIDTH-1], qx_i} - {ex_i[COORD_WIDTH-1], ex_i};
    vy_q <= {qy_i[COORD_WIDTH-1], qy_i} - {ey_i[COORD_WIDTH-1], ey_i};
  end

  // stage 2: products
  always_ff @(posedge clk_i) begin
    dxdx_q <= P'(dx_q) * P'(dx_q);
    dydy_q <= P'(dy_q) * P'(dy_q);
    wxdx_q <= P'(wx_q) * P'(dx_q);
    wydy_q <= P'(wy_q) * P'(dy_q);
    wxdy_q <= P'(wx_q) * P'(dy_q);
    wydx_q <= P'(wy_q) * P'(dx_q);
    wxwx_q <= P'(wx_q) * P'(wx_q);
    wywy_q <= P'(wy_q) * P'(wy_q);
    vxvx_q <= P'(vx_q) * P'(vx_q);
    vyvy_q <= P'(vy_q) * P'(vy_q);
  end

  // stage 3: sums
  always_ff @(posedge clk_i) begin
    den_o   <= dxdx_q + dydy_q;
    dot_o   <= S'(wxdx_q) + S'(wydy_q);
    cross_o <= S'(wxdy_q) - S'(wydx_q);
    lenw_o  <= wxwx_q + wywy_q;
    lenv_o  <= vxvx_q + vyvy_q;
  end

  assign valid_o = v3_q;

endmodule

// File: sv/psd_select.sv
module psd_select
  import psd_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic [2*COORD_WIDTH+1:0]        den_i,
  input  logic signed [2*COORD_WIDTH+2:0] dot_i,
  input  logic signed [2*COORD_WIDTH+2:0] cross_i,
  input  logic [2*COORD_WIDTH+1:0]        lenw_i,
  input  logic [2*COORD_WIDTH+1:0]        lenv_i,
  output logic                            valid_o,
  output logic [4*COORD_WIDTH+3:0]        num_o,
  output logic [2*COORD_WIDTH+1:0]        den_o
);

  localparam int unsigned L  = COORD_WIDTH + 1;
  localparam int unsigned CW = 2 * L;
  localparam int unsigned NW = 4 * L;
  localparam int unsigned S  = 2 * COORD_WIDTH + 3;

  ctl_t           c4_q, c5_q;
  logic [CW-1:0]  den4_q, den5_q, len4_q, len5_q, mag_q;
  logic [CW-1:0]  mag_d;
  logic [2*L-1:0] hh_q, hl_q, ll_q;
  ctl_t           c4_d;
  logic           v6_q;

  always_comb begin
    c4_d.valid = valid_i;
    if (den_i == '0 || dot_i[S-1]) begin
      c4_d.sel = SEL_START;
    end else if (dot_i >= $signed({1'b0, den_i})) begin
      c4_d.sel = SEL_END;
    end else begin
      c4_d.sel = SEL_PERP;
    end
  end

  assign mag_d = cross_i[S-1] ? CW'(-cross_i) : CW'(cross_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c4_q <= '{valid: 1'b0, sel: SEL_START};
      c5_q <= '{valid: 1'b0, sel: SEL_START};
      v6_q <= 1'b0;
    end else begin
      c4_q <= c4_d;
      c5_q <= c4_q;
      v6_q <= c5_q.valid;
    end
  end

  // stage 4: case, magnitude; stage 5: partial products; stage 6: operands
  always_ff @(posedge clk_i) begin
    den4_q <= den_i;
    len4_q <= (c4_d.sel == SEL_END) ? lenv_i : lenw_i;
    mag_q  <= mag_d;
    den5_q <= den4_q;
    len5_q <= len4_q;
    hh_q   <= (2*L)'(mag_q[CW-1:L]) * (2*L)'(mag_q[CW-1:L]);
    hl_q   <= (2*L)'(mag_q[CW-1:L]) * (2*L)'(mag_q[L-1:0]);
    ll_q   <= (2*L)'(mag_q[L-1:0]) * (2*L)'(mag_q[L-1:0]);
    if (c5_q.sel == SEL_PERP) begin
      num_o <= (NW'(hh_q) << (2*L)) + (NW'(hl_q) << (L+1)) + NW'(ll_q);
      den_o <= den5_q;
    end else begin
      num_o <= NW'(len5_q);
      den_o <= CW'(1);
    end
  end

  assign valid_o = v6_q;

endmodule

// File: sv/psd_root_stage.sv
module psd_root_stage
  import psd_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned BIT_POS     = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [4*COORD_WIDTH+3:0]   rem_i,
  input  logic [4*COORD_WIDTH+3:0]   acc_i,
  input  logic [2*COORD_WIDTH+1:0]   den_i,
  input  logic [COORD_WIDTH:0]       root_i,
  output logic                       valid_o,
  output logic [4*COORD_WIDTH+3:0]   rem_o,
  output logic [4*COORD_WIDTH+3:0]   acc_o,
  output logic [2*COORD_WIDTH+1:0]   den_o,
  output logic [COORD_WIDTH:0]       root_o
);

  localparam int unsigned NW = 4 * COORD_WIDTH + 4;
  localparam int unsigned DW = 2 * COORD_WIDTH + 2;
  localparam int unsigned OB = COORD_WIDTH + 1;

  // rem = num - y^2*den, acc = y*den; trying y + 2^b adds 2^(b+1)*acc + 4^b*den
  logic [NW:0] den_x, delta, rem_x;
  logic        take;

  assign den_x = {{(NW+1-DW){1'b0}}, den_i};
  assign rem_x = {1'b0, rem_i};
  assign delta = ({1'b0, acc_i} << (BIT_POS + 1)) + (den_x << (2 * BIT_POS));
  assign take  = (delta <= rem_x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    den_o <= den_i;
    if (take) begin
      rem_o  <= NW'(rem_x - delta);
      acc_o  <= acc_i + NW'(den_x << BIT_POS);
      root_o <= root_i | (OB'(1) << BIT_POS);
    end else begin
      rem_o  <= rem_i;
      acc_o  <= acc_i;
      root_o <= root_i;
    end
  end

endmodule

// File: sv/point_segment_distance.sv
// Point to segment distance, signed Q8.8 coordinates in, unsigned Q9.8 out.
// Input channel: drive query, start and end coordinates with start high; the
// beat is taken at that edge. busy is held low, so a beat may be given in
// every cycle.
// Output channel: gap_length_o is valid for one cycle while done_o is high;
// the receiver cannot stall and must take it in that cycle.
// Pipeline from the accepting edge to the edge that raises done_o: three
// geometry stages, three stages of case selection and squaring, and one
// root stage per result bit.
// Throughput: one beat per cycle, set by the fully pipelined root chain.
// Results leave in the order the beats came in.
// Reset clears all valid bits, dropping any beats in flight; no state remains.
module point_segment_distance
  import psd_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] query_x_i,
  input  logic signed [COORD_WIDTH-1:0] query_y_i,
  input  logic signed [COORD_WIDTH-1:0] start_x_i,
  input  logic signed [COORD_WIDTH-1:0] start_y_i,
  input  logic signed [COORD_WIDTH-1:0] end_x_i,
  input  logic signed [COORD_WIDTH-1:0] end_y_i,
  output logic                          done_o,
  output logic [COORD_WIDTH:0]          gap_length_o
);

  localparam int unsigned NW = 4 * COORD_WIDTH + 4;
  localparam int unsigned DW = 2 * COORD_WIDTH + 2;
  localparam int unsigned OB = COORD_WIDTH + 1;
  localparam int unsigned SW = 2 * COORD_WIDTH + 3;

  logic                 fv;
  logic [DW-1:0]        fden, flenw, flenv;
  logic signed [SW-1:0] fdot, fcross;
  logic                 sv_v;
  logic [NW-1:0]        snum;
  logic [DW-1:0]        sden;

  logic          rv   [OB+1];
  logic [NW-1:0] rrem [OB+1];
  logic [NW-1:0] racc [OB+1];
  logic [DW-1:0] rden [OB+1];
  logic [OB-1:0] rrt  [OB+1];

  assign busy = 1'b0;

  psd_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .valid_i (start & ~busy),
    .qx_i    (query_x_i),
    .qy_i    (query_y_i),
    .sx_i    (start_x_i),
    .sy_i    (start_y_i),
    .ex_i    (end_x_i),
    .ey_i    (end_y_i),
    .valid_o (fv),
    .den_o   (fden),
    .dot_o   (fdot),
    .cross_o (fcross),
    .lenw_o  (flenw),
    .lenv_o  (flenv)
  );

  psd_select #(.COORD_WIDTH(COORD_WIDTH)) u_select (
    .clk_i, .rst_ni,
    .valid_i (fv),
    .den_i   (fden),
    .dot_i   (fdot),
    .cross_i (fcross),
    .lenw_i  (flenw),
    .lenv_i  (flenv),
    .valid_o (sv_v),
    .num_o   (snum),
    .den_o   (sden)
  );

  assign rv[0]   = sv_v;
  assign rrem[0] = snum;
  assign racc[0] = '0;
  assign rden[0] = sden;
  assign rrt[0]  = '0;

  for (genvar i = 0; i < OB; i++) begin : g_root
    psd_root_stage #(
      .COORD_WIDTH (COORD_WIDTH),
      .BIT_POS     (OB - 1 - i)
    ) u_stage (
      .clk_i, .rst_ni,
      .valid_i (rv[i]),
      .rem_i   (rrem[i]),
      .acc_i   (racc[i]),
      .den_i   (rden[i]),
      .root_i  (rrt[i]),
      .valid_o (rv[i+1]),
      .rem_o   (rrem[i+1]),
      .acc_o   (racc[i+1]),
      .den_o   (rden[i+1]),
      .root_o  (rrt[i+1])
    );
  end

  assign done_o       = rv[OB];
  assign gap_length_o = rrt[OB];

endmodule
